/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// shared types, codes and helpers of the checked 32-bit alu
// ----------------------------------------------------------------------------
package cia_pkg;

	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned DIV_STAGES = WORD_BITS;

	typedef enum logic [3:0] {
		ACT_OR   = 4'd0,
		ACT_XOR  = 4'd1,
		ACT_AND  = 4'd2,
		ACT_ADD  = 4'd3,
		ACT_SUB  = 4'd4,
		ACT_MUL  = 4'd5,
		ACT_DIV  = 4'd6,
		ACT_MOD  = 4'd7,
		ACT_SHR  = 4'd8,
		ACT_SHL  = 4'd9,
		ACT_NEG  = 4'd10,
		ACT_PLUS = 4'd11,
		ACT_NOT  = 4'd12
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_DIVIDE   = 3'd2,
		ST_SHIFT    = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	// item info that rides alongside the divider
	typedef struct packed {
		logic [WORD_BITS-1:0] res;
		logic                 rsg;
		status_t              st;
		logic                 use_div;
		logic                 is_mod;
		logic                 neg_q;
		logic                 neg_r;
	} side_t;

	// one restoring step: acc holds {remainder, dividend/quotient}
	function automatic logic [2*WORD_BITS-1:0] div_step(
		input logic [2*WORD_BITS-1:0] acc,
		input logic [WORD_BITS-1:0]   d
	);
		logic [WORD_BITS:0] top;
		logic [WORD_BITS:0] diff;
		logic [2*WORD_BITS-1:0] nxt;
		top  = acc[2*WORD_BITS-1:WORD_BITS-1];
		diff = top - {1'b0, d};
		if (top >= {1'b0, d}) begin
			nxt = {diff[WORD_BITS-1:0], acc[WORD_BITS-2:0], 1'b1};
		end else begin
			nxt = {acc[2*WORD_BITS-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

/* rtl/checked_int32_alu.sv */
// ----------------------------------------------------------------------------
// checked_int32_alu
// pipelined 32-bit integer alu with overflow, divide and shift checks
// ----------------------------------------------------------------------------
// channel   dir  tdata                       tuser
// s_axis    in   left_operand, right_operand action, operand_signed
// m_axis    out  result_value                result_signed, status
//
// every operation takes the same path of 35 register stages and the result
// shows on m_axis from the output register, one transaction per cycle
// sustained while the output is taken; the 32-stage divider sets the depth.
// one global enable stalls all stages together when the output
// register is full and not taken. reset clears only the valid bits.
module checked_int32_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // left_operand[31:0], right_operand[63:32]
	input  logic [7:0]  s_axis_tuser,  // action[3:0], operand_signed[4], zero[7:5]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // result_value[31:0]
	output logic [7:0]  m_axis_tuser   // result_signed[0], status[3:1], zero[7:4]
);
	import cia_pkg::*;

	// global advance: output slot free or being drained
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: registered input transaction
	logic                 valid_s1;
	logic [3:0]           act_s1;
	logic [WORD_BITS-1:0] a_s1, b_s1;
	logic                 sg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= s_axis_tuser[3:0];
			sg_s1  <= s_axis_tuser[4];
			a_s1   <= s_axis_tdata[31:0];
			b_s1   <= s_axis_tdata[63:32];
		end
	end

	// stage 1 logic: simple ops, checks, magnitudes for mul and div
	logic [WORD_BITS:0]   sum, diff;
	logic [WORD_BITS-1:0] mag_a, mag_b, shr_v;
	logic                 shift_big, shift_full;
	side_t                side1;
	logic                 is_mul1;

	always_comb begin
		sum        = {1'b0, a_s1} + {1'b0, b_s1};
		diff       = {1'b0, a_s1} - {1'b0, b_s1};
		mag_a      = (sg_s1 && a_s1[WORD_BITS-1]) ? (~a_s1 + 1'b1) : a_s1;
		mag_b      = (sg_s1 && b_s1[WORD_BITS-1]) ? (~b_s1 + 1'b1) : b_s1;
		shift_big  = b_s1 > WORD_BITS;
		shift_full = b_s1 == WORD_BITS;
		shr_v      = sg_s1 ? WORD_BITS'($signed(a_s1) >>> b_s1[4:0]) : (a_s1 >> b_s1[4:0]);
		is_mul1    = 1'b0;
		side1         = '0;
		side1.rsg     = sg_s1;
		side1.st      = ST_OK;
		side1.is_mod  = act_s1 == ACT_MOD;
		side1.neg_q   = sg_s1 && (a_s1[WORD_BITS-1] ^ b_s1[WORD_BITS-1]);
		side1.neg_r   = sg_s1 && a_s1[WORD_BITS-1];
		case (act_s1)
			ACT_OR:  side1.res = a_s1 | b_s1;
			ACT_XOR: side1.res = a_s1 ^ b_s1;
			ACT_AND: side1.res = a_s1 & b_s1;
			ACT_ADD: begin
				side1.res = sum[WORD_BITS-1:0];
				if (sg_s1 ? (a_s1[WORD_BITS-1] == b_s1[WORD_BITS-1] &&
						sum[WORD_BITS-1] != a_s1[WORD_BITS-1]) : sum[WORD_BITS]) begin
					side1.st = ST_OVERFLOW;
				end
			end
			ACT_SUB: begin
				side1.res = diff[WORD_BITS-1:0];
				if (sg_s1 ? (a_s1[WORD_BITS-1] != b_s1[WORD_BITS-1] &&
						diff[WORD_BITS-1] != a_s1[WORD_BITS-1]) : diff[WORD_BITS]) begin
					side1.st = ST_OVERFLOW;
				end
			end
			ACT_MUL: is_mul1 = 1'b1;
			ACT_DIV, ACT_MOD: begin
				side1.use_div = 1'b1;
				if (b_s1 == '0) begin
					side1.st = ST_DIVIDE;
				end else if (act_s1 == ACT_DIV && sg_s1 && a_s1 == {1'b1, {(WORD_BITS-1){1'b0}}}
						&& b_s1 == {WORD_BITS{1'b1}}) begin
					// minimum divided by minus one
					side1.st = ST_DIVIDE;
				end
			end
			ACT_SHR: begin
				if (shift_big) begin
					side1.st = ST_SHIFT;
				end else if (shift_full) begin
					side1.res = {WORD_BITS{sg_s1 && a_s1[WORD_BITS-1]}};
				end else begin
					side1.res = shr_v;
				end
			end
			ACT_SHL: begin
				if (shift_big) begin
					side1.st = ST_SHIFT;
				end else if (!shift_full) begin
					side1.res = a_s1 << b_s1[4:0];
				end
			end
			ACT_NEG: begin
				if (!sg_s1 && a_s1[WORD_BITS-1]) begin
					side1.st = ST_OVERFLOW;
				end else begin
					side1.res = ~a_s1 + 1'b1;
					side1.rsg = 1'b1;
				end
			end
			ACT_PLUS: side1.res = a_s1;
			ACT_NOT:  side1.res = ~a_s1;
			default:  side1.st = ST_INVALID;
		endcase
	end

	// stage 2: product and carried item
	logic                   valid_s2, is_mul_s2, neg_p_s2, sg_s2;
	side_t                  side_s2;
	logic [WORD_BITS-1:0]   mag_a_s2, mag_b_s2;
	logic [2*WORD_BITS-1:0] prod_s2;

	cia_mul u_mul (
		.clk     (clk),
		.en      (en),
		.mag_a   (mag_a),
		.mag_b   (mag_b),
		.prod_s2 (prod_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2   <= side1;
			is_mul_s2 <= is_mul1;
			neg_p_s2  <= side1.neg_q;
			sg_s2     <= sg_s1;
			mag_a_s2  <= mag_a;
			mag_b_s2  <= mag_b;
		end
	end

	// stage 2 logic: product range check and sign
	side_t side2;
	always_comb begin
		side2 = side_s2;
		if (is_mul_s2) begin
			side2.res = neg_p_s2 ? (~prod_s2[WORD_BITS-1:0] + 1'b1) : prod_s2[WORD_BITS-1:0];
			if (prod_s2[2*WORD_BITS-1:WORD_BITS] != '0) begin
				side2.st = ST_OVERFLOW;
			end else if (sg_s2 && prod_s2[WORD_BITS-1] &&
					!(neg_p_s2 && prod_s2[WORD_BITS-2:0] == '0)) begin
				// magnitude beyond the signed range
				side2.st = ST_OVERFLOW;
			end
		end
	end

	// divider stages, carrying everything else alongside
	logic                 valid_d;
	logic [WORD_BITS-1:0] quo_d, rem_d;
	side_t                side_d;

	cia_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.in_n      (mag_a_s2),
		.in_d      (mag_b_s2),
		.in_side   (side2),
		.out_valid (valid_d),
		.out_quo   (quo_d),
		.out_rem   (rem_d),
		.out_side  (side_d)
	);

	// final select and sign restore
	logic [WORD_BITS-1:0] fin_res;
	logic                 fin_rsg;
	always_comb begin
		fin_res = side_d.res;
		fin_rsg = side_d.rsg;
		if (side_d.use_div) begin
			if (side_d.is_mod) begin
				fin_res = side_d.neg_r ? (~rem_d + 1'b1) : rem_d;
			end else begin
				fin_res = side_d.neg_q ? (~quo_d + 1'b1) : quo_d;
			end
		end
		if (side_d.st != ST_OK) begin
			fin_res = '0;
			fin_rsg = 1'b0;
		end
	end

	// output register
	logic [WORD_BITS-1:0] res_q;
	logic                 rsg_q;
	status_t              st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fin_res;
			rsg_q <= fin_rsg;
			st_q  <= side_d.st;
		end
	end

	assign m_axis_tdata = res_q;
	assign m_axis_tuser = {4'b0, st_q, rsg_q};

	// failed checks never leak a value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st_q != ST_OK |-> res_q == '0 && !rsg_q)
		else $error("nonzero result with error status");

	// input side opens exactly when the output slot can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready out of step with output");

	// a held output transaction keeps its value and status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(res_q) && $stable(st_q))
		else $error("output changed while stalled");

	// a negate that passes its check always gives a signed result
	a_neg_signed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en && act_s1 == ACT_NEG && side1.st == ST_OK |-> side1.rsg)
		else $error("negate result not signed");

endmodule

/* rtl/cia_mul.sv */
// ----------------------------------------------------------------------------
// cia_mul
// registered 32x32 unsigned magnitude multiplier
// ----------------------------------------------------------------------------
module cia_mul (
	input  logic                            clk,
	input  logic                            en,
	input  logic [cia_pkg::WORD_BITS-1:0]   mag_a,
	input  logic [cia_pkg::WORD_BITS-1:0]   mag_b,
	output logic [2*cia_pkg::WORD_BITS-1:0] prod_s2
);
	import cia_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= {{WORD_BITS{1'b0}}, mag_a} * {{WORD_BITS{1'b0}}, mag_b};
		end
	end

endmodule

/* rtl/cia_div.sv */
// ----------------------------------------------------------------------------
// cia_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cia_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [cia_pkg::WORD_BITS-1:0] in_n,
	input  logic [cia_pkg::WORD_BITS-1:0] in_d,
	input  cia_pkg::side_t                in_side,
	output logic                          out_valid,
	output logic [cia_pkg::WORD_BITS-1:0] out_quo,
	output logic [cia_pkg::WORD_BITS-1:0] out_rem,
	output cia_pkg::side_t                out_side
);
	import cia_pkg::*;

	logic                   valid_s [DIV_STAGES];
	logic [2*WORD_BITS-1:0] acc_s   [DIV_STAGES];
	logic [WORD_BITS-1:0]   d_s     [DIV_STAGES];
	side_t                  side_s  [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int i = 1; i < DIV_STAGES; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0]  <= div_step({{WORD_BITS{1'b0}}, in_n}, in_d);
			d_s[0]    <= in_d;
			side_s[0] <= in_side;
			for (int i = 1; i < DIV_STAGES; i++) begin
				acc_s[i]  <= div_step(acc_s[i-1], d_s[i-1]);
				d_s[i]    <= d_s[i-1];
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_quo   = acc_s[DIV_STAGES-1][WORD_BITS-1:0];
	assign out_rem   = acc_s[DIV_STAGES-1][2*WORD_BITS-1:WORD_BITS];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

/* verif/alu_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker
// watches both stream channels of the checked alu, works out the expected
// result of every accepted operation and compares it with what comes out
// ----------------------------------------------------------------------------
module alu_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic [7:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [7:0]  m_axis_tuser,
	output int          error_count,
	output int          pending_results,
	output int          results_seen
);
	import cia_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        sgn;
		logic [2:0]  st;
	} alu_result_t;

	alu_result_t result_fifo[$];

	// compute the checked result of one operation
	function automatic alu_result_t checked_result(logic [3:0] act, logic [31:0] a,
		logic [31:0] b, logic sg);
		alu_result_t r;
		longint sa, sb, wide;
		logic [63:0] uw;
		sa = sg ? longint'($signed(a)) : longint'({32'd0, a});
		sb = sg ? longint'($signed(b)) : longint'({32'd0, b});
		r.value = '0;
		r.sgn = sg;
		r.st = ST_OK;
		case (act)
			ACT_OR:  r.value = a | b;
			ACT_XOR: r.value = a ^ b;
			ACT_AND: r.value = a & b;
			ACT_ADD, ACT_SUB, ACT_MUL: begin
				if (act == ACT_ADD) wide = sa + sb;
				else if (act == ACT_SUB) wide = sa - sb;
				else begin
					uw = {32'd0, a} * {32'd0, b};
					wide = sg ? sa * sb : longint'(uw);
				end
				if (act == ACT_MUL && !sg) begin
					if (uw[63:32] != 0) r.st = ST_OVERFLOW;
					else r.value = uw[31:0];
				end else if (sg ? (wide < -64'sd2147483648 || wide > 64'sd2147483647)
					: (wide < 0 || wide > 64'sd4294967295)) begin
					r.st = ST_OVERFLOW;
				end else begin
					r.value = wide[31:0];
				end
			end
			ACT_DIV, ACT_MOD: begin
				if (b == 0) r.st = ST_DIVIDE;
				// most negative over minus one: quotient overflows, remainder 0
				else if (sg && a == 32'h8000_0000 && b == 32'hffff_ffff) begin
					if (act == ACT_DIV) r.st = ST_DIVIDE;
				end else begin
					wide = (act == ACT_DIV) ? sa / sb : sa % sb;
					r.value = wide[31:0];
				end
			end
			ACT_SHR, ACT_SHL: begin
				if (b > 32) r.st = ST_SHIFT;
				else if (b == 32) r.value = (act == ACT_SHR && sg && a[31]) ? '1 : '0;
				else if (act == ACT_SHL) r.value = a << b[4:0];
				else if (sg) r.value = $signed(a) >>> b[4:0];
				else r.value = a >> b[4:0];
			end
			ACT_NEG: begin
				// unsigned values above the signed max cannot be negated
				if (!sg && a[31]) r.st = ST_OVERFLOW;
				else begin
					r.value = -a;
					r.sgn = 1'b1;
				end
			end
			ACT_PLUS: r.value = a;
			ACT_NOT:  r.value = ~a;
			default:  r.st = ST_INVALID;
		endcase
		if (r.st != ST_OK) begin
			r.value = '0;
			r.sgn = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_result_t want, got;
		if (!arst_n) begin
			error_count <= 0;
			results_seen <= 0;
			pending_results <= 0;
			result_fifo.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				result_fifo.push_back(checked_result(s_axis_tuser[3:0], s_axis_tdata[31:0],
					s_axis_tdata[63:32], s_axis_tuser[4]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[3:1]};
				results_seen <= results_seen + 1;
				if (result_fifo.size() == 0) begin
					error_count <= error_count + 1;
					if (error_count < 10)
						$display("unexpected transaction: value %h signed %b status %0d",
							got.value, got.sgn, got.st);
				end else begin
					want = result_fifo.pop_front();
					if (got !== want || m_axis_tuser[7:4] !== 4'd0) begin
						error_count <= error_count + 1;
						if (error_count < 10)
							$display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
								want.value, want.sgn, want.st,
								got.value, got.sgn, got.st);
					end
				end
			end
			pending_results <= result_fifo.size();
		end
	end

endmodule

/* verif/tb_checked_int32_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checked_int32_alu
// drives directed corner operations then random ones into the checked alu,
// with random gaps on input and output; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_checked_int32_alu;
	import cia_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // left_operand[31:0], right_operand[63:32]
	logic [7:0]  s_axis_tuser = '0;   // action[3:0], operand_signed[4], zero[7:5]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // result_value[31:0]
	logic [7:0]  m_axis_tuser;        // result_signed[0], status[3:1], zero[7:4]
	int          error_count, pending_results, results_seen;
	int          sent = 0;

	localparam int RANDOM_ITEMS = 1750;
	localparam int LATENCY = 35;

	always #1 clk = ~clk;

	checked_int32_alu dut (.*);
	alu_result_checker checker_i (.*);

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// operands that hit the interesting edges more often than uniform values
	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return $urandom_range(0, 40);
			5: return $urandom_range(0, 65535);
			6: return -$urandom_range(1, 65535);
			default: return $urandom;
		endcase
	endfunction

	// present one transaction at the falling edge and hold it until taken
	task automatic send_op(logic [3:0] act, logic [31:0] a, logic [31:0] b, logic sg);
		int g;
		g = gap_length();
		repeat (g) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, a};
		s_axis_tuser <= {3'b000, sg, act};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	// output side: random backpressure with mostly short stalls
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
			@(negedge clk);
			m_axis_tready <= (g == 0);
			repeat (g) @(negedge clk);
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [3:0] act;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed corners
		send_op(ACT_OR, 32'hffff_ffff, 32'h0000_0000, 1'b0);
		send_op(ACT_XOR, 32'haaaa_5555, 32'hffff_ffff, 1'b1);
		send_op(ACT_AND, 32'hffff_ffff, 32'h1234_5678, 1'b0);
		send_op(ACT_ADD, 32'hffff_ffff, 32'd1, 1'b0);              // unsigned carry out
		send_op(ACT_ADD, 32'h7fff_ffff, 32'd1, 1'b1);              // signed overflow
		send_op(ACT_SUB, 32'd0, 32'd1, 1'b0);                      // unsigned borrow
		send_op(ACT_SUB, 32'h8000_0000, 32'd1, 1'b1);
		send_op(ACT_MUL, 32'h0001_0000, 32'h0001_0000, 1'b0);
		send_op(ACT_MUL, 32'h8000_0000, 32'hffff_ffff, 1'b1);
		send_op(ACT_DIV, 32'd5, 32'd0, 1'b0);                      // divide by zero
		send_op(ACT_MOD, 32'd5, 32'd0, 1'b1);
		send_op(ACT_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b1);      // min / -1
		send_op(ACT_MOD, 32'h8000_0000, 32'hffff_ffff, 1'b1);      // min mod -1
		send_op(ACT_MOD, -32'sd7, 32'd2, 1'b1);                    // sign of dividend
		send_op(ACT_SHR, 32'h8000_0000, 32'd32, 1'b1);             // full sign fill
		send_op(ACT_SHR, 32'h8000_0000, 32'd31, 1'b1);
		send_op(ACT_SHL, 32'hffff_ffff, 32'd32, 1'b0);
		send_op(ACT_SHL, 32'd1, 32'd33, 1'b1);                     // shift too large
		send_op(ACT_SHR, 32'd1, 32'hffff_ffff, 1'b0);
		send_op(ACT_NEG, 32'h8000_0000, 32'd0, 1'b1);              // wraps
		send_op(ACT_NEG, 32'h8000_0000, 32'd0, 1'b0);              // unsigned too large
		send_op(ACT_NEG, 32'h7fff_ffff, 32'd0, 1'b0);
		send_op(ACT_PLUS, 32'hdead_beef, 32'd9, 1'b1);
		send_op(ACT_NOT, 32'h0f0f_0f0f, 32'd0, 1'b0);
		send_op(4'd13, 32'd1, 32'd1, 1'b0);
		send_op(4'd15, 32'hffff_ffff, 32'hffff_ffff, 1'b1);

		// hold off until the pipe has drained once
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(posedge clk);

		repeat (RANDOM_ITEMS) begin
			act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
				: 4'($urandom_range(0, 12));
			send_op(act, edge_word(), edge_word(), 1'($urandom));
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (pending_results != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d operations, checked %0d results", sent, results_seen);
		$display("covered all actions, invalid codes, edge operands and stalls");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
